>>> rtl/deauth_flood_window_detector_defines.svh
// assertion macros for the deauth flood window detector
`ifndef DEAUTH_FLOOD_WINDOW_DETECTOR_DEFINES_SVH
`define DEAUTH_FLOOD_WINDOW_DETECTOR_DEFINES_SVH

`ifndef SYNTHESIS
`define DFWD_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("dfwd assertion failed");
`define DFWD_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("dfwd assertion failed");
`else
`define DFWD_ASSERT(name, clk, rstn, prop)
`define DFWD_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

>>> rtl/dfwd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dfwd_pkg;

  localparam logic [11:0] MIN_FRAME_LEN     = 12'd24;
  localparam logic [1:0]  FC_TYPE_MGMT      = 2'h0;
  localparam logic [3:0]  FC_SUBTYPE_DEAUTH = 4'hC;
  localparam logic [9:0]  COUNT_MAX         = 10'd1023;
  localparam logic [9:0]  THRESHOLD_RESET   = 10'd1000;
  localparam logic [31:0] WINDOW_RESET      = 32'd10000000;

  localparam logic CFG_THRESHOLD = 1'b0;
  localparam logic CFG_WINDOW    = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_INSERT,
    ST_EMIT
  } dfwd_state_t;

  typedef struct packed {
    logic load;
    logic expire;
    logic insert;
    logic emit;
  } dfwd_cmd_t;

  typedef struct packed {
    logic in_deauth;
    logic ring_empty;
    logic expired;
    logic out_free;
  } dfwd_sts_t;

endpackage

`default_nettype wire

>>> rtl/dfwd_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface dfwd_in_if;
  logic               valid;
  logic               ready;
  logic               is_management;
  logic [11:0]        frame_length;
  logic [15:0]        frame_control;
  logic [47:0]        sender_mac;
  logic signed [7:0]  signal_rssi;
  logic [62:0]        timestamp_us;

  modport source (
    output valid, is_management, frame_length, frame_control, sender_mac,
           signal_rssi, timestamp_us,
    input  ready
  );
  modport sink (
    input  valid, is_management, frame_length, frame_control, sender_mac,
           signal_rssi, timestamp_us,
    output ready
  );
endinterface

interface dfwd_out_if;
  logic               valid;
  logic               ready;
  logic               is_deauth;
  logic               alert;
  logic [47:0]        attacker_mac;
  logic signed [7:0]  attacker_rssi;
  logic [9:0]         window_count;
  logic [31:0]        total_count;

  modport source (
    output valid, is_deauth, alert, attacker_mac, attacker_rssi, window_count,
           total_count,
    input  ready
  );
  modport sink (
    input  valid, is_deauth, alert, attacker_mac, attacker_rssi, window_count,
           total_count,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/dfwd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module dfwd_ctrl
  import dfwd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire dfwd_sts_t sts,
  output dfwd_cmd_t      cmd
);

  dfwd_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = sts.in_deauth ? ST_READ : ST_EMIT;
        end
      end
      ST_READ: begin
        state_nxt = sts.ring_empty ? ST_INSERT : ST_CHECK;
      end
      ST_CHECK: begin
        state_nxt = sts.expired ? ST_READ : ST_INSERT;
      end
      ST_INSERT: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_READ: begin
      end
      ST_CHECK: begin
        cmd.expire = sts.expired;
      end
      ST_INSERT: begin
        cmd.insert = 1'b1;
      end
      ST_EMIT: begin
        cmd.emit = sts.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/dfwd_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module dfwd_datapath
  import dfwd_pkg::*;
#(
  parameter int RING_DEPTH = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [9:0]        alert_threshold,
  input  wire logic [31:0]       window_us,
  input  wire logic              is_management,
  input  wire logic [11:0]       frame_length,
  input  wire logic [15:0]       frame_control,
  input  wire logic [47:0]       sender_mac,
  input  wire logic signed [7:0] signal_rssi,
  input  wire logic [62:0]       timestamp_us,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output logic                   out_is_deauth,
  output logic                   out_alert,
  output logic [47:0]            out_attacker_mac,
  output logic signed [7:0]      out_attacker_rssi,
  output logic [9:0]             out_window_count,
  output logic [31:0]            out_total_count,
  input  wire dfwd_cmd_t         cmd,
  output dfwd_sts_t              sts
);

  localparam int IW    = $clog2(RING_DEPTH);
  localparam int CNT_W = (IW > 10) ? IW : 10;

  function automatic logic [IW-1:0] ring_adv(input logic [IW-1:0] idx);
    ring_adv = (idx == IW'(RING_DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  // stamp store
  logic [62:0] ring_mem [RING_DEPTH];
  logic [62:0] rd_data_r;

  // per-beat payload
  logic               deauth_r;
  logic [47:0]        mac_r;
  logic signed [7:0]  rssi_r;
  logic [62:0]        ts_r;
  logic signed [63:0] limit_r;
  logic [IW-1:0]      count_r;
  logic               alert_r;

  // control state
  logic [IW-1:0] oldest_r, oldest_nxt;
  logic [IW-1:0] next_r, next_nxt;
  logic [31:0]   total_r, total_nxt;
  logic          out_valid_r, out_valid_nxt;

  // insert math
  logic [IW-1:0]    oldest_ins;
  logic [IW-1:0]    next_ins;
  logic [IW:0]      count_wide;
  logic [IW-1:0]    count_ins;
  logic [CNT_W-1:0] count_ext;
  logic [CNT_W-1:0] cnt_out_ext;
  logic [9:0]       count_sat;

  assign sts.in_deauth = is_management && (frame_length >= MIN_FRAME_LEN) &&
                         (frame_control[3:2] == FC_TYPE_MGMT) &&
                         (frame_control[7:4] == FC_SUBTYPE_DEAUTH);
  assign sts.ring_empty = (oldest_r == next_r);
  assign sts.expired    = $signed({1'b0, rd_data_r}) < limit_r;
  assign sts.out_free   = !out_valid_r || out_ready;

  always_comb begin
    oldest_ins = (ring_adv(next_r) == oldest_r) ? ring_adv(oldest_r) : oldest_r;
    next_ins   = ring_adv(next_r);
    count_wide = {1'b0, next_ins} - {1'b0, oldest_ins} +
                 ((next_ins < oldest_ins) ? (IW+1)'(RING_DEPTH) : '0);
    count_ins  = count_wide[IW-1:0];
    count_ext  = CNT_W'(count_r);
    cnt_out_ext = (count_ext > CNT_W'(COUNT_MAX)) ? CNT_W'(COUNT_MAX) : count_ext;
    count_sat  = cnt_out_ext[9:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      ring_mem[next_r] <= ts_r;
    end
    rd_data_r <= ring_mem[oldest_r];
  end

  always_comb begin
    oldest_nxt    = oldest_r;
    next_nxt      = next_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r;
    if (cmd.load && sts.in_deauth) begin
      total_nxt = total_r + 32'd1;
    end
    if (cmd.expire) begin
      oldest_nxt = ring_adv(oldest_r);
    end
    if (cmd.insert) begin
      oldest_nxt = oldest_ins;
      next_nxt   = next_ins;
    end
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      if (deauth_r && alert_r) begin
        oldest_nxt = '0;
        next_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_r    <= '0;
      next_r      <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      oldest_r    <= oldest_nxt;
      next_r      <= next_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      deauth_r <= sts.in_deauth;
      mac_r    <= sender_mac;
      rssi_r   <= signal_rssi;
      ts_r     <= timestamp_us;
      limit_r  <= $signed({1'b0, timestamp_us}) - $signed({32'd0, window_us});
    end
    if (cmd.insert) begin
      count_r <= count_ins;
      alert_r <= CNT_W'(count_ins) >= CNT_W'(alert_threshold);
    end
    if (cmd.emit) begin
      out_is_deauth     <= deauth_r;
      out_alert         <= deauth_r && alert_r;
      out_attacker_mac  <= (deauth_r && alert_r) ? mac_r : '0;
      out_attacker_rssi <= (deauth_r && alert_r) ? rssi_r : '0;
      out_window_count  <= deauth_r ? count_sat : '0;
      out_total_count   <= total_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

>>> rtl/deauth_flood_window_detector.sv
// a non-deauth beat goes from idle straight to emit, where its result is registered
// deauth beat: read, then check unless the ring is empty, read and check again per expired stamp, insert, emit
// the next beat is taken only once the control is back in idle, and emit holds while the
// previous result still waits in the output register for out ready
// a new beat is taken while the previous result still waits in the output register
// synchronous active-low reset: ring empty, total zero, threshold and window to defaults, no result valid
`timescale 1ns / 1ps
`default_nettype none
`include "deauth_flood_window_detector_defines.svh"

module deauth_flood_window_detector
  import dfwd_pkg::*;
#(
  parameter int RING_DEPTH = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  dfwd_in_if.sink          in_bus,
  dfwd_out_if.source       out_bus,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  logic [9:0]  threshold_r, threshold_nxt;
  logic [31:0] window_r, window_nxt;

  dfwd_cmd_t cmd;
  dfwd_sts_t sts;
  logic      in_ready;

  always_comb begin
    threshold_nxt = threshold_r;
    window_nxt    = window_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_THRESHOLD: threshold_nxt = cfg_wdata[9:0];
        CFG_WINDOW:    window_nxt    = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RESET;
      window_r    <= WINDOW_RESET;
    end else begin
      threshold_r <= threshold_nxt;
      window_r    <= window_nxt;
    end
  end

  assign in_bus.ready = in_ready;

  dfwd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dfwd_datapath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .alert_threshold   (threshold_r),
    .window_us         (window_r),
    .is_management     (in_bus.is_management),
    .frame_length      (in_bus.frame_length),
    .frame_control     (in_bus.frame_control),
    .sender_mac        (in_bus.sender_mac),
    .signal_rssi       (in_bus.signal_rssi),
    .timestamp_us      (in_bus.timestamp_us),
    .out_ready         (out_bus.ready),
    .out_valid         (out_bus.valid),
    .out_is_deauth     (out_bus.is_deauth),
    .out_alert         (out_bus.alert),
    .out_attacker_mac  (out_bus.attacker_mac),
    .out_attacker_rssi (out_bus.attacker_rssi),
    .out_window_count  (out_bus.window_count),
    .out_total_count   (out_bus.total_count),
    .cmd               (cmd),
    .sts               (sts)
  );

  `DFWD_ASSERT(a_busy_after_take, clk, rst_n, in_bus.valid && in_bus.ready |=> !in_bus.ready)
  `DFWD_ASSERT(a_alert_needs_deauth, clk, rst_n, out_bus.valid && out_bus.alert |-> out_bus.is_deauth)
  `DFWD_ASSERT(a_idle_fields_zero, clk, rst_n, out_bus.valid && !out_bus.is_deauth |-> out_bus.window_count == 10'd0 && out_bus.attacker_mac == 48'd0)
  `DFWD_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_bus.valid)

endmodule

`default_nettype wire

>>> verif/deauth_flood_window_detector_tb.sv
`timescale 1ns / 1ps

module deauth_flood_window_detector_tb;
  import dfwd_pkg::*;

  localparam int RING_SLOTS = 1024;
  localparam int CYCLE_LIMIT = 500000;
  localparam int REPORT_MAX = 10;
  localparam logic [62:0] TS_MAX = {63{1'b1}};
  localparam logic [15:0] FC_DEAUTH = 16'h00C0;

  typedef struct packed {
    logic              is_management;
    logic [11:0]       frame_length;
    logic [15:0]       frame_control;
    logic [47:0]       sender_mac;
    logic signed [7:0] signal_rssi;
    logic [62:0]       timestamp_us;
  } frame_t;

  typedef struct packed {
    logic              is_deauth;
    logic              alert;
    logic [47:0]       attacker_mac;
    logic signed [7:0] attacker_rssi;
    logic [9:0]        window_count;
    logic [31:0]       total_count;
  } verdict_t;

  typedef enum {
    BREAK_MGMT,
    BREAK_LENGTH,
    BREAK_TYPE,
    BREAK_SUBTYPE,
    BREAK_ANY
  } frame_fault_t;

  typedef enum {
    SINK_OPEN,
    SINK_RANDOM,
    SINK_THROTTLED
  } sink_mode_t;

  class deauth_rate_scoreboard;
    logic [62:0] stamp_ring [RING_SLOTS];
    int unsigned oldest_slot;
    int unsigned next_slot;
    bit [31:0]   deauth_total;
    bit [9:0]    threshold;
    bit [31:0]   window_len;
    verdict_t    pending_verdicts [$];
    int unsigned mismatches;

    function new();
      oldest_slot = 0;
      next_slot = 0;
      deauth_total = '0;
      threshold = THRESHOLD_RESET;
      window_len = WINDOW_RESET;
      mismatches = 0;
    endfunction

    function void write_reg(logic idx, bit [31:0] value);
      if (idx == CFG_THRESHOLD) begin
        threshold = value[9:0];
      end else begin
        window_len = value;
      end
    endfunction

    // predicts the verdict of one accepted frame
    function void note_frame(frame_t f);
      verdict_t v;
      longint horizon;
      int unsigned held;
      v = '0;
      if (!f.is_management || f.frame_length < MIN_FRAME_LEN ||
          f.frame_control[3:2] != FC_TYPE_MGMT ||
          f.frame_control[7:4] != FC_SUBTYPE_DEAUTH) begin
        v.total_count = deauth_total;
        pending_verdicts.push_back(v);
        return;
      end
      deauth_total = deauth_total + 32'd1;
      horizon = longint'({1'b0, f.timestamp_us}) - longint'({32'd0, window_len});
      while (oldest_slot != next_slot &&
             longint'({1'b0, stamp_ring[oldest_slot]}) < horizon) begin
        oldest_slot = (oldest_slot + 1) % RING_SLOTS;
      end
      if ((next_slot + 1) % RING_SLOTS == oldest_slot) begin
        oldest_slot = (oldest_slot + 1) % RING_SLOTS;
      end
      stamp_ring[next_slot] = f.timestamp_us;
      next_slot = (next_slot + 1) % RING_SLOTS;
      held = (next_slot + RING_SLOTS - oldest_slot) % RING_SLOTS;
      v.is_deauth = 1'b1;
      v.window_count = (held > COUNT_MAX) ? COUNT_MAX : 10'(held);
      v.total_count = deauth_total;
      if (held >= threshold) begin
        v.alert = 1'b1;
        v.attacker_mac = f.sender_mac;
        v.attacker_rssi = f.signal_rssi;
        oldest_slot = 0;
        next_slot = 0;
      end
      pending_verdicts.push_back(v);
    endfunction

    function void check_verdict(verdict_t got);
      verdict_t want;
      string bad;
      bad = "";
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("unexpected result beat: deauth=%0b alert=%0b mac=%h rssi=%0d win=%0d total=%0d",
                   got.is_deauth, got.alert, got.attacker_mac, got.attacker_rssi,
                   got.window_count, got.total_count);
        end
        return;
      end
      want = pending_verdicts.pop_front();
      if (got.is_deauth !== want.is_deauth) bad = {bad, " is_deauth"};
      if (got.alert !== want.alert) bad = {bad, " alert"};
      if (got.attacker_mac !== want.attacker_mac) bad = {bad, " attacker_mac"};
      if (got.attacker_rssi !== want.attacker_rssi) bad = {bad, " attacker_rssi"};
      if (got.window_count !== want.window_count) bad = {bad, " window_count"};
      if (got.total_count !== want.total_count) bad = {bad, " total_count"};
      if (bad != "") begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("mismatch in%s at %0t", bad, $realtime);
          $display("  exp: deauth=%0b alert=%0b mac=%h rssi=%0d win=%0d total=%0d",
                   want.is_deauth, want.alert, want.attacker_mac, want.attacker_rssi,
                   want.window_count, want.total_count);
          $display("  got: deauth=%0b alert=%0b mac=%h rssi=%0d win=%0d total=%0d",
                   got.is_deauth, got.alert, got.attacker_mac, got.attacker_rssi,
                   got.window_count, got.total_count);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_index;
  logic [31:0] cfg_wdata;

  dfwd_in_if  in_bus ();
  dfwd_out_if out_bus ();

  deauth_rate_scoreboard scoreboard;
  int burst_left;
  int cycle_count;
  sink_mode_t sink_mode;
  int sink_span;

  deauth_flood_window_detector #(
    .RING_DEPTH(RING_SLOTS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_bus(in_bus),
    .out_bus(out_bus),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  // result side stalls in stretches: open, random, or one beat in four
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      sink_mode <= SINK_OPEN;
      sink_span <= 0;
    end else begin
      if (sink_span == 0) begin
        sink_mode <= sink_mode_t'($urandom_range(0, 2));
        sink_span <= $urandom_range(20, 150);
      end else begin
        sink_span <= sink_span - 1;
      end
      case (sink_mode)
        SINK_OPEN: out_bus.ready <= 1'b1;
        SINK_RANDOM: out_bus.ready <= ($urandom_range(0, 9) < 6);
        default: out_bus.ready <= (sink_span[1:0] == 2'd0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) begin
        scoreboard.note_frame('{in_bus.is_management, in_bus.frame_length,
                                in_bus.frame_control, in_bus.sender_mac,
                                in_bus.signal_rssi, in_bus.timestamp_us});
      end
      if (out_bus.valid && out_bus.ready) begin
        scoreboard.check_verdict('{out_bus.is_deauth, out_bus.alert,
                                   out_bus.attacker_mac, out_bus.attacker_rssi,
                                   out_bus.window_count, out_bus.total_count});
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  function automatic frame_t build_frame(logic mgmt, logic [11:0] len, logic [15:0] fc,
                                         logic [47:0] mac, logic [7:0] rssi,
                                         logic [62:0] ts);
    frame_t f;
    f.is_management = mgmt;
    f.frame_length = len;
    f.frame_control = fc;
    f.sender_mac = mac;
    f.signal_rssi = rssi;
    f.timestamp_us = ts;
    return f;
  endfunction

  function automatic frame_t random_frame(bit deauth_form, logic [62:0] ts);
    frame_t f;
    logic [63:0] wide;
    frame_fault_t fault;
    wide = {$urandom, $urandom};
    f.sender_mac = wide[47:0];
    f.signal_rssi = 8'($urandom_range(0, 255));
    f.timestamp_us = ts;
    f.is_management = 1'b1;
    f.frame_length = 12'($urandom_range(MIN_FRAME_LEN, 4095));
    f.frame_control = 16'($urandom_range(0, 16'hFFFF));
    f.frame_control[3:2] = FC_TYPE_MGMT;
    f.frame_control[7:4] = FC_SUBTYPE_DEAUTH;
    if (!deauth_form) begin
      fault = frame_fault_t'($urandom_range(0, 4));
      case (fault)
        BREAK_MGMT: f.is_management = 1'b0;
        BREAK_LENGTH: f.frame_length = 12'($urandom_range(0, MIN_FRAME_LEN - 1));
        BREAK_TYPE: f.frame_control[3:2] = 2'($urandom_range(1, 3));
        BREAK_SUBTYPE: begin
          f.frame_control[7:4] = 4'($urandom_range(0, 14));
          if (f.frame_control[7:4] == FC_SUBTYPE_DEAUTH) f.frame_control[7:4] = 4'hF;
        end
        default: begin
          f.is_management = 1'($urandom_range(0, 1));
          f.frame_length = 12'($urandom_range(0, 4095));
          f.frame_control = 16'($urandom_range(0, 16'hFFFF));
        end
      endcase
    end
    return f;
  endfunction

  // one beat on the input channel, bursts separated by random gaps
  task automatic send_frame(frame_t f);
    in_bus.valid <= 1'b1;
    in_bus.is_management <= f.is_management;
    in_bus.frame_length <= f.frame_length;
    in_bus.frame_control <= f.frame_control;
    in_bus.sender_mac <= f.sender_mac;
    in_bus.signal_rssi <= f.signal_rssi;
    in_bus.timestamp_us <= f.timestamp_us;
    do @(posedge clk); while (!in_bus.ready);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        in_bus.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  endtask

  task automatic settle();
    in_bus.valid <= 1'b0;
    while (scoreboard.pending_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    scoreboard.write_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic program_detector(logic [9:0] thr, logic [31:0] win);
    settle();
    write_reg(CFG_THRESHOLD, {22'd0, thr});
    write_reg(CFG_WINDOW, win);
    cfg_we <= 1'b0;
  endtask

  task automatic run_directed();
    send_frame(build_frame(1'b0, 12'd100, FC_DEAUTH, 48'h0123456789AB, 8'd0, 63'd0));
    send_frame(build_frame(1'b1, 12'd23, FC_DEAUTH, 48'h0123456789AB, 8'd0, 63'd0));
    send_frame(build_frame(1'b1, 12'd0, FC_DEAUTH, 48'h0, 8'd0, 63'd0));
    send_frame(build_frame(1'b1, 12'd24, 16'h00C4, 48'h1, 8'd1, 63'd0));
    send_frame(build_frame(1'b1, 12'd24, 16'h00C8, 48'h1, 8'd1, 63'd0));
    send_frame(build_frame(1'b1, 12'd24, 16'h00CC, 48'h1, 8'd1, 63'd0));
    send_frame(build_frame(1'b1, 12'd24, 16'h00D0, 48'h1, 8'd1, 63'd0));
    send_frame(build_frame(1'b1, 12'd24, 16'h00B0, 48'h1, 8'd1, 63'd0));
    send_frame(build_frame(1'b1, 12'd24, 16'hFFFF, 48'h1, 8'd1, 63'd0));
    send_frame(build_frame(1'b1, 12'd24, FC_DEAUTH, 48'h0, 8'h80, 63'd0));
    send_frame(build_frame(1'b1, 12'd4095, 16'hFFC3, {48{1'b1}}, 8'h7F, TS_MAX));
    // time steps back to zero
    send_frame(build_frame(1'b1, 12'd4095, FC_DEAUTH, 48'hA5A5A5A5A5A5, 8'hFF, 63'd0));
    send_frame(build_frame(1'b0, 12'd4095, 16'hFFFF, {48{1'b1}}, 8'h7F, TS_MAX));
    // zero threshold alerts on every counted frame
    program_detector(10'd0, 32'd1);
    send_frame(build_frame(1'b1, 12'd64, FC_DEAUTH, 48'h112233445566, 8'hC4, 63'd5));
    send_frame(build_frame(1'b1, 12'd64, FC_DEAUTH, 48'h665544332211, 8'h10, 63'd5));
    send_frame(build_frame(1'b1, 12'd64, 16'h00E0, 48'h665544332211, 8'h10, 63'd7));
    program_detector(10'd2, 32'd1);
    send_frame(build_frame(1'b1, 12'd30, FC_DEAUTH, 48'hDEADBEEF0001, 8'hD8, 63'd100));
    send_frame(build_frame(1'b1, 12'd30, FC_DEAUTH, 48'hDEADBEEF0002, 8'hD9, 63'd101));
    send_frame(build_frame(1'b1, 12'd30, FC_DEAUTH, 48'hDEADBEEF0003, 8'hDA, 63'd200));
    send_frame(build_frame(1'b1, 12'd30, FC_DEAUTH, 48'hDEADBEEF0004, 8'hDB, 63'd202));
    send_frame(build_frame(1'b1, 12'd30, FC_DEAUTH, 48'hDEADBEEF0005, 8'hDC, 63'd202));
    program_detector(10'd3, 32'hFFFF_FFFF);
    send_frame(build_frame(1'b1, 12'd24, FC_DEAUTH, 48'h0, 8'd0, TS_MAX - 63'd4));
    send_frame(build_frame(1'b1, 12'd24, FC_DEAUTH, 48'h1, 8'd2, 63'd0));
    send_frame(build_frame(1'b1, 12'd24, FC_DEAUTH, 48'h2, 8'd3, TS_MAX));
  endtask

  task automatic run_traffic(logic [9:0] thr, logic [31:0] win, int beats, int deauth_pct,
                             int step_max, int back_pct, logic [62:0] ts_start);
    logic [62:0] ts;
    logic [63:0] stepped;
    int back;
    program_detector(thr, win);
    ts = ts_start;
    for (int i = 0; i < beats; i++) begin
      if ($urandom_range(0, 99) < back_pct) begin
        back = $urandom_range(0, 4 * step_max + 1);
        ts = (ts < back) ? 63'd0 : ts - back;
      end else begin
        stepped = {1'b0, ts} + $urandom_range(0, step_max);
        ts = stepped[63] ? TS_MAX : stepped[62:0];
      end
      send_frame(random_frame($urandom_range(0, 99) < deauth_pct, ts));
    end
  endtask

  initial begin
    logic [63:0] wide;
    scoreboard = new();
    burst_left = 1;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_THRESHOLD;
    cfg_wdata = '0;
    in_bus.valid = 1'b0;
    in_bus.is_management = 1'b0;
    in_bus.frame_length = '0;
    in_bus.frame_control = '0;
    in_bus.sender_mac = '0;
    in_bus.signal_rssi = '0;
    in_bus.timestamp_us = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    run_directed();
    // largest threshold with the widest window fills the ring to the alert
    run_traffic(10'd1023, 32'hFFFF_FFFF, 1120, 97, 2000, 0, 63'd0);
    wide = {$urandom, $urandom};
    run_traffic(10'd1, 32'd1000, 60, 80, 500, 0, wide[62:0]);
    run_traffic(10'd8, 32'd200, 150, 85, 60, 10, 63'($urandom_range(0, 100000)));
    wide = {$urandom, $urandom};
    run_traffic(10'd30, 32'd5000, 150, 90, 400, 3, wide[62:0]);
    run_traffic(THRESHOLD_RESET, 32'd1, 60, 85, 3, 5, TS_MAX - 63'd200);
    wide = {$urandom, $urandom};
    run_traffic(10'($urandom_range(2, 15)), $urandom_range(10, 3000), 150, 85,
                $urandom_range(5, 300), 5, wide[62:0]);
    settle();

    if (scoreboard.mismatches == 0 && scoreboard.pending_verdicts.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/dfwd_pkg.sv
rtl/dfwd_if.sv
rtl/dfwd_ctrl.sv
rtl/dfwd_datapath.sv
rtl/deauth_flood_window_detector.sv
verif/deauth_flood_window_detector_tb.sv
